// ===== hdl/cqc_pkg.sv =====
// Shared types and constants for the circular queue with cancel.
// No dependencies; compile before every other file of the block.
package cqc_pkg;

    localparam int QUEUE_DEPTH_DEF  = 16;
    localparam int ID_BITS_DEF      = 16;
    localparam int PAYLOAD_BITS_DEF = 32;

    localparam int CMD_W = 3;

    localparam logic [CMD_W-1:0] CMD_ENQ    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DEQ    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd4;

    typedef enum logic [2:0] {
        OP_ENQ,
        OP_DEQ,
        OP_PEEK,
        OP_CLEAR,
        OP_REMOVE,
        OP_NOP
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_WALK
    } back_state_t;

endpackage

// ===== hdl/circular_queue_with_cancel_unit.sv =====
// Circular request queue with remove-by-id; top level of the block.
// Requests pass through the front-end command buffer to the back end. Enqueue, clear,
// unknown codes and empty-queue reads load the response register on acceptance; dequeue
// and peek read the RAM first; remove-by-id walks every entry, one read at a time. The
// back end takes a command only when idle with the response register free.
// Reset empties the queue; slot storage is not cleared.
module circular_queue_with_cancel_unit #(
    parameter int QUEUE_DEPTH  = cqc_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS      = cqc_pkg::ID_BITS_DEF,
    parameter int PAYLOAD_BITS = cqc_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_ready,
    input  logic [cqc_pkg::CMD_W-1:0]        cmd,
    input  logic [ID_BITS-1:0]               req_id,
    input  logic [PAYLOAD_BITS-1:0]          req_payload,
    output logic                             rsp_valid,
    input  logic                             rsp_ready,
    output logic                             ok,
    output logic [ID_BITS-1:0]               out_id,
    output logic [PAYLOAD_BITS-1:0]          out_payload,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] occupancy,
    output logic                             is_empty,
    output logic                             is_full
);
    import cqc_pkg::*;

    logic                    cmd_valid;
    logic                    cmd_ready;
    op_t                     cmd_op;
    logic [ID_BITS-1:0]      cmd_id;
    logic [PAYLOAD_BITS-1:0] cmd_payload;

    cqc_front #(
        .ID_BITS      (ID_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .cmd         (cmd),
        .req_id      (req_id),
        .req_payload (req_payload),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd_op      (cmd_op),
        .cmd_id      (cmd_id),
        .cmd_payload (cmd_payload)
    );

    cqc_back #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .ID_BITS      (ID_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd_op      (cmd_op),
        .cmd_id      (cmd_id),
        .cmd_payload (cmd_payload),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .ok          (ok),
        .out_id      (out_id),
        .out_payload (out_payload),
        .occupancy   (occupancy),
        .is_empty    (is_empty),
        .is_full     (is_full)
    );

`ifndef SYNTH
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (occupancy <= QUEUE_DEPTH))
        else $error("occupancy above queue depth");

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(is_empty && is_full))
        else $error("empty and full flagged together");

    a_fail_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !ok) |-> (out_id == '0 && out_payload == '0))
        else $error("failed response carries head data");
`endif

endmodule

// ===== hdl/cqc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cqc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/cqc_front.sv =====
// Front end: accepts requests, decodes the command code and buffers
// decoded commands in a two-entry queue toward the back end. Uses cqc_pkg.
module cqc_front #(
    parameter int ID_BITS      = cqc_pkg::ID_BITS_DEF,
    parameter int PAYLOAD_BITS = cqc_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    output logic                     req_ready,
    input  logic [cqc_pkg::CMD_W-1:0] cmd,
    input  logic [ID_BITS-1:0]       req_id,
    input  logic [PAYLOAD_BITS-1:0]  req_payload,
    output logic                     cmd_valid,
    input  logic                     cmd_ready,
    output cqc_pkg::op_t             cmd_op,
    output logic [ID_BITS-1:0]       cmd_id,
    output logic [PAYLOAD_BITS-1:0]  cmd_payload
);
    import cqc_pkg::*;

    op_t                    op_mem_reg  [2];
    logic [ID_BITS-1:0]     id_mem_reg  [2];
    logic [PAYLOAD_BITS-1:0] pay_mem_reg [2];
    logic                   wr_ptr_reg;
    logic                   wr_ptr_next;
    logic                   rd_ptr_reg;
    logic                   rd_ptr_next;
    logic [1:0]             fill_reg;
    logic [1:0]             fill_next;
    logic                   push;
    logic                   pop;
    op_t                    dec_op;

    always_comb
    begin
        unique case (cmd)
            CMD_ENQ:    dec_op = OP_ENQ;
            CMD_DEQ:    dec_op = OP_DEQ;
            CMD_PEEK:   dec_op = OP_PEEK;
            CMD_CLEAR:  dec_op = OP_CLEAR;
            CMD_REMOVE: dec_op = OP_REMOVE;
            default:    dec_op = OP_NOP;
        endcase
    end

    assign req_ready = (fill_reg != 2'd2);
    assign cmd_valid = (fill_reg != 2'd0);
    assign push      = req_valid && req_ready;
    assign pop       = cmd_valid && cmd_ready;

    assign cmd_op      = op_mem_reg[rd_ptr_reg];
    assign cmd_id      = id_mem_reg[rd_ptr_reg];
    assign cmd_payload = pay_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            op_mem_reg[wr_ptr_reg]  <= dec_op;
            id_mem_reg[wr_ptr_reg]  <= req_id;
            pay_mem_reg[wr_ptr_reg] <= req_payload;
        end
    end

endmodule

// ===== hdl/cqc_back.sv =====
// Back end: executes decoded commands against two RAM banks (active and
// scratch) and holds the response register. Uses cqc_pkg and cqc_ram.
module cqc_back #(
    parameter int QUEUE_DEPTH  = cqc_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS      = cqc_pkg::ID_BITS_DEF,
    parameter int PAYLOAD_BITS = cqc_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cmd_valid,
    output logic                             cmd_ready,
    input  cqc_pkg::op_t                     cmd_op,
    input  logic [ID_BITS-1:0]               cmd_id,
    input  logic [PAYLOAD_BITS-1:0]          cmd_payload,
    output logic                             rsp_valid,
    input  logic                             rsp_ready,
    output logic                             ok,
    output logic [ID_BITS-1:0]               out_id,
    output logic [PAYLOAD_BITS-1:0]          out_payload,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] occupancy,
    output logic                             is_empty,
    output logic                             is_full
);
    import cqc_pkg::*;

    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W = ID_BITS + PAYLOAD_BITS;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);

    back_state_t             state_reg,     state_next;
    logic [PTR_W-1:0]        head_reg,      head_next;
    logic [PTR_W-1:0]        tail_reg,      tail_next;
    logic [CNT_W-1:0]        count_reg,     count_next;
    logic                    bank_reg,      bank_next;
    op_t                     op_reg,        op_next;
    logic [ID_BITS-1:0]      key_reg,       key_next;
    logic [PTR_W-1:0]        walk_ptr_reg,  walk_ptr_next;
    logic [CNT_W-1:0]        issue_cnt_reg, issue_cnt_next;
    logic [CNT_W-1:0]        kept_reg,      kept_next;
    logic                    hit_reg,       hit_next;
    logic                    data_vld_reg,  data_vld_next;

    logic                    rsp_valid_reg, rsp_valid_next;
    logic                    rsp_ok_reg,    rsp_ok_next;
    logic [ID_BITS-1:0]      rsp_id_reg,    rsp_id_next;
    logic [PAYLOAD_BITS-1:0] rsp_pay_reg,   rsp_pay_next;
    logic [CNT_W-1:0]        rsp_count_reg, rsp_count_next;
    logic                    load_rsp;
    logic                    rsp_free;

    logic [1:0]              wr_we;
    logic [PTR_W-1:0]        wr_addr;
    logic [ENTRY_W-1:0]      wr_data;
    logic [PTR_W-1:0]        rd_addr;
    logic [ENTRY_W-1:0]      rd_data0;
    logic [ENTRY_W-1:0]      rd_data1;
    logic [ENTRY_W-1:0]      rd_entry;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] ptr);
        wrap_inc = (ptr == LAST_PTR) ? '0 : ptr + PTR_W'(1);
    endfunction

    cqc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_bank0 (
        .clk   (clk),
        .we    (wr_we[0]),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_data0)
    );

    cqc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_bank1 (
        .clk   (clk),
        .we    (wr_we[1]),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_data1)
    );

    assign rd_entry = bank_reg ? rd_data1 : rd_data0;
    assign rsp_free = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        bank_next      = bank_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        walk_ptr_next  = walk_ptr_reg;
        issue_cnt_next = issue_cnt_reg;
        kept_next      = kept_reg;
        hit_next       = hit_reg;
        data_vld_next  = data_vld_reg;
        cmd_ready      = 1'b0;
        load_rsp       = 1'b0;
        rsp_ok_next    = 1'b0;
        rsp_id_next    = '0;
        rsp_pay_next   = '0;
        wr_we          = 2'b00;
        wr_addr        = tail_reg;
        wr_data        = {cmd_id, cmd_payload};
        rd_addr        = head_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                cmd_ready = rsp_free;
                if (cmd_valid && rsp_free)
                begin
                    unique case (cmd_op) inside
                        OP_ENQ:
                        begin
                            load_rsp = 1'b1;
                            if (count_reg != DEPTH_CNT)
                            begin
                                wr_we       = bank_reg ? 2'b10 : 2'b01;
                                tail_next   = wrap_inc(tail_reg);
                                count_next  = count_reg + CNT_W'(1);
                                rsp_ok_next = 1'b1;
                            end
                        end
                        OP_DEQ, OP_PEEK:
                        begin
                            if (count_reg == '0)
                            begin
                                load_rsp = 1'b1;
                            end
                            else
                            begin
                                op_next    = cmd_op;
                                state_next = ST_READ;
                            end
                        end
                        OP_CLEAR:
                        begin
                            head_next   = '0;
                            tail_next   = '0;
                            count_next  = '0;
                            rsp_ok_next = 1'b1;
                            load_rsp    = 1'b1;
                        end
                        OP_REMOVE:
                        begin
                            key_next       = cmd_id;
                            walk_ptr_next  = head_reg;
                            issue_cnt_next = '0;
                            kept_next      = '0;
                            hit_next       = 1'b0;
                            data_vld_next  = 1'b0;
                            state_next     = ST_WALK;
                        end
                        default:
                        begin
                            load_rsp = 1'b1;
                        end
                    endcase
                end
            end

            ST_READ:
            begin
                load_rsp     = 1'b1;
                rsp_ok_next  = 1'b1;
                rsp_id_next  = rd_entry[ENTRY_W-1:PAYLOAD_BITS];
                rsp_pay_next = rd_entry[PAYLOAD_BITS-1:0];
                if (op_reg == OP_DEQ)
                begin
                    head_next  = wrap_inc(head_reg);
                    count_next = count_reg - CNT_W'(1);
                end
                state_next = ST_IDLE;
            end

            ST_WALK:
            begin
                // compact survivors into the scratch bank starting at slot 0
                if (data_vld_reg)
                begin
                    if (rd_entry[ENTRY_W-1:PAYLOAD_BITS] == key_reg)
                    begin
                        hit_next = 1'b1;
                    end
                    else
                    begin
                        wr_we     = bank_reg ? 2'b01 : 2'b10;
                        wr_addr   = kept_reg[PTR_W-1:0];
                        wr_data   = rd_entry;
                        kept_next = kept_reg + CNT_W'(1);
                    end
                end
                if (issue_cnt_reg != count_reg)
                begin
                    rd_addr        = walk_ptr_reg;
                    walk_ptr_next  = wrap_inc(walk_ptr_reg);
                    issue_cnt_next = issue_cnt_reg + CNT_W'(1);
                    data_vld_next  = 1'b1;
                end
                else
                begin
                    data_vld_next = 1'b0;
                end
                if (issue_cnt_reg == count_reg && !data_vld_reg)
                begin
                    load_rsp = 1'b1;
                    // on a match the scratch bank becomes the live one
                    if (hit_reg)
                    begin
                        rsp_ok_next = 1'b1;
                        bank_next   = !bank_reg;
                        head_next   = '0;
                        tail_next   = kept_reg[PTR_W-1:0];
                        count_next  = kept_reg;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        rsp_count_next = count_next;
        rsp_valid_next = load_rsp || (rsp_valid_reg && !rsp_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            bank_reg      <= 1'b0;
            op_reg        <= OP_NOP;
            walk_ptr_reg  <= '0;
            issue_cnt_reg <= '0;
            kept_reg      <= '0;
            hit_reg       <= 1'b0;
            data_vld_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            bank_reg      <= bank_next;
            op_reg        <= op_next;
            walk_ptr_reg  <= walk_ptr_next;
            issue_cnt_reg <= issue_cnt_next;
            kept_reg      <= kept_next;
            hit_reg       <= hit_next;
            data_vld_reg  <= data_vld_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        if (load_rsp)
        begin
            rsp_ok_reg    <= rsp_ok_next;
            rsp_id_reg    <= rsp_id_next;
            rsp_pay_reg   <= rsp_pay_next;
            rsp_count_reg <= rsp_count_next;
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign ok          = rsp_ok_reg;
    assign out_id      = rsp_id_reg;
    assign out_payload = rsp_pay_reg;
    assign occupancy   = rsp_count_reg;
    assign is_empty    = (rsp_count_reg == '0);
    assign is_full     = (rsp_count_reg == DEPTH_CNT);

endmodule

// ===== test/circular_queue_with_cancel_unit_tb.sv =====
// Testbench for the circular request queue with remove-by-id.
// Needs cqc_pkg and circular_queue_with_cancel_unit; tracks queue contents in a
// shadow model and checks every response in order against it.
module circular_queue_with_cancel_unit_tb;

    import cqc_pkg::*;

    localparam int DEPTH = QUEUE_DEPTH_DEF;
    localparam int ID_W  = ID_BITS_DEF;
    localparam int PAY_W = PAYLOAD_BITS_DEF;
    localparam int OCC_W = $clog2(DEPTH + 1);

    // codes the block must ignore
    localparam logic [CMD_W-1:0] CMD_RSVD_A = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD_B = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD_C = 3'd7;

    localparam int RANDOM_ITEMS = 650;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic              ok;
        logic [ID_W-1:0]   id;
        logic [PAY_W-1:0]  pay;
        logic [OCC_W-1:0]  occ;
        logic              is_empty;
        logic              is_full;
    } queue_rsp_t;

    class ring_queue_tracker;
        logic [ID_W-1:0]  slot_id [DEPTH];
        logic [PAY_W-1:0] slot_pay[DEPTH];
        int unsigned      head_idx;
        int unsigned      tail_idx;
        int unsigned      held;
        queue_rsp_t       awaited[$];
        int unsigned      mismatches;

        function new();
            head_idx   = 0;
            tail_idx   = 0;
            held       = 0;
            mismatches = 0;
        endfunction

        function void apply_request(logic [CMD_W-1:0] c, logic [ID_W-1:0] id,
                                    logic [PAY_W-1:0] pay);
            queue_rsp_t       r;
            logic [ID_W-1:0]  keep_id [DEPTH];
            logic [PAY_W-1:0] keep_pay[DEPTH];
            int unsigned      kept;
            int unsigned      pos;
            bit               hit;
            r    = '0;
            kept = 0;
            hit  = 1'b0;
            case (c)
                CMD_ENQ:
                    if (held < DEPTH)
                    begin
                        slot_id[tail_idx]  = id;
                        slot_pay[tail_idx] = pay;
                        tail_idx = (tail_idx + 1) % DEPTH;
                        held++;
                        r.ok = 1'b1;
                    end
                CMD_DEQ, CMD_PEEK:
                    if (held != 0)
                    begin
                        r.ok  = 1'b1;
                        r.id  = slot_id[head_idx];
                        r.pay = slot_pay[head_idx];
                        if (c == CMD_DEQ)
                        begin
                            head_idx = (head_idx + 1) % DEPTH;
                            held--;
                        end
                    end
                CMD_CLEAR:
                begin
                    head_idx = 0;
                    tail_idx = 0;
                    held     = 0;
                    r.ok     = 1'b1;
                end
                CMD_REMOVE:
                begin
                    pos = head_idx;
                    for (int i = 0; i < held; i++)
                    begin
                        if (slot_id[pos] == id)
                            hit = 1'b1;
                        else
                        begin
                            keep_id[kept]  = slot_id[pos];
                            keep_pay[kept] = slot_pay[pos];
                            kept++;
                        end
                        pos = (pos + 1) % DEPTH;
                    end
                    // compact survivors to slot 0 only when something matched
                    if (hit)
                    begin
                        for (int i = 0; i < kept; i++)
                        begin
                            slot_id[i]  = keep_id[i];
                            slot_pay[i] = keep_pay[i];
                        end
                        held     = kept;
                        head_idx = 0;
                        tail_idx = kept % DEPTH;
                        r.ok     = 1'b1;
                    end
                end
                default: ;
            endcase
            r.occ      = OCC_W'(held);
            r.is_empty = (held == 0);
            r.is_full  = (held == DEPTH);
            awaited.push_back(r);
        endfunction

        function void compare_response(queue_rsp_t got);
            queue_rsp_t want;
            if (awaited.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: response with none outstanding: ok=%0b id=%h pay=%h occ=%0d",
                             $time, got.ok, got.id, got.pay, got.occ);
                return;
            end
            want = awaited.pop_front();
            if (got.ok !== want.ok || got.id !== want.id || got.pay !== want.pay ||
                got.occ !== want.occ || got.is_empty !== want.is_empty ||
                got.is_full !== want.is_full)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t: response mismatch", $time);
                    $display("  expected ok=%0b id=%h pay=%h occ=%0d empty=%0b full=%0b",
                             want.ok, want.id, want.pay, want.occ, want.is_empty, want.is_full);
                    $display("  actual   ok=%0b id=%h pay=%h occ=%0d empty=%0b full=%0b",
                             got.ok, got.id, got.pay, got.occ, got.is_empty, got.is_full);
                end
            end
        endfunction

        function int unsigned pending();
            return awaited.size();
        endfunction
    endclass

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               req_valid   = 1'b0;
    logic               req_ready;
    logic [CMD_W-1:0]   cmd         = CMD_ENQ;
    logic [ID_W-1:0]    req_id      = '0;
    logic [PAY_W-1:0]   req_payload = '0;
    logic               rsp_valid;
    logic               rsp_ready   = 1'b0;
    logic               ok;
    logic [ID_W-1:0]    out_id;
    logic [PAY_W-1:0]   out_payload;
    logic [OCC_W-1:0]   occupancy;
    logic               is_empty;
    logic               is_full;

    logic               hold_start  = 1'b0;
    int unsigned        hold_left   = 0;
    int unsigned        send_idle_pct = 0;
    int unsigned        rcv_idle_pct  = 0;

    ring_queue_tracker  tracker = new();

    circular_queue_with_cancel_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .cmd         (cmd),
        .req_id      (req_id),
        .req_payload (req_payload),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .ok          (ok),
        .out_id      (out_id),
        .out_payload (out_payload),
        .occupancy   (occupancy),
        .is_empty    (is_empty),
        .is_full     (is_full)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Response side: random stalls, or a long hold-off once asked for.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_start)
        begin
            rsp_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
        begin
            rsp_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
            rsp_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            tracker.compare_response({ok, out_id, out_payload, occupancy, is_empty, is_full});
    end

    task automatic send_request(input logic [CMD_W-1:0] c, input logic [ID_W-1:0] id,
                                input logic [PAY_W-1:0] pay);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid   <= 1'b1;
        cmd         <= c;
        req_id      <= id;
        req_payload <= pay;
        do
            @(posedge clk);
        while (!req_ready);
        tracker.apply_request(c, id, pay);
    endtask

    // Mostly a handful of ids so that removes hit; sometimes any id.
    function automatic logic [ID_W-1:0] pick_id();
        if ($urandom_range(0, 99) < 80)
            return ID_W'($urandom_range(0, 5));
        return ID_W'($urandom_range(0, 65535));
    endfunction

    task automatic send_random_request();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            send_request(CMD_ENQ, pick_id(), $urandom);
        else if (roll < 62)
            send_request(CMD_DEQ, pick_id(), $urandom);
        else if (roll < 74)
            send_request(CMD_PEEK, pick_id(), $urandom);
        else if (roll < 92)
            send_request(CMD_REMOVE, pick_id(), $urandom);
        else if (roll < 96)
            send_request(CMD_CLEAR, pick_id(), $urandom);
        else if (roll < 97)
            send_request(CMD_RSVD_A, pick_id(), $urandom);
        else if (roll < 98)
            send_request(CMD_RSVD_B, pick_id(), $urandom);
        else
            send_request(CMD_RSVD_C, pick_id(), $urandom);
    endtask

    initial
    begin
        #5_000_000;
        $display("FAIL circular_queue_with_cancel_unit");
        $finish;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty queue: every read and remove fails, reserved codes do nothing
        send_request(CMD_DEQ, '0, '0);
        send_request(CMD_PEEK, '0, '0);
        send_request(CMD_REMOVE, '0, '0);
        send_request(CMD_RSVD_A, 16'hFFFF, 32'hFFFF_FFFF);
        send_request(CMD_RSVD_C, 16'h1234, 32'h5555_AAAA);
        send_request(CMD_CLEAR, '0, '0);
        send_request(CMD_ENQ, 16'h0000, 32'h0000_0000);
        send_request(CMD_ENQ, 16'hFFFF, 32'hFFFF_FFFF);
        send_request(CMD_PEEK, '0, '0);
        send_request(CMD_REMOVE, 16'hFFFF, '0);
        send_request(CMD_DEQ, '0, '0);

        // fill to the top, reject one more, then remove several at once
        for (int i = 0; i < DEPTH; i++)
            send_request(CMD_ENQ, (i % 3 == 0) ? 16'hFFFF : ID_W'(i % 3), ~PAY_W'(i));
        send_request(CMD_ENQ, 16'h0007, 32'hDEAD_BEEF);
        send_request(CMD_PEEK, '0, '0);
        send_request(CMD_REMOVE, 16'h0001, '0);
        send_request(CMD_REMOVE, 16'h0009, '0);
        send_request(CMD_DEQ, '0, '0);
        send_request(CMD_CLEAR, '0, '0);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n < RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 30;
                rcv_idle_pct  = 78;
            end
            else if (n < 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 78;
                rcv_idle_pct  = 30;
            end
            else
            begin
                send_idle_pct = 0;
                rcv_idle_pct  = 0;
            end
            // stall the response side for a long stretch while requests keep coming
            if (n == 2 * RANDOM_ITEMS / 3)
            begin
                req_valid  <= 1'b0;
                hold_start <= 1'b1;
                @(posedge clk);
                hold_start <= 1'b0;
            end
            send_random_request();
        end
        req_valid <= 1'b0;

        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (tracker.mismatches == 0)
            $display("PASS circular_queue_with_cancel_unit");
        else
            $display("FAIL circular_queue_with_cancel_unit");
        $finish;
    end

endmodule
